@@ src/ffsa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ffsa_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int ADDR_W  = 17;
  localparam int SIZE_W  = 17;
  localparam int START_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [SIZE_W-1:0] MAX_REGION = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE  = 2'd1;

  localparam logic FUNC_CLAIM = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_BAD_SIZE  = 3'd1,
    STAT_NO_FIT    = 3'd2,
    STAT_NOT_ALLOC = 3'd3,
    STAT_FULL      = 3'd4
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } seg_t;

  localparam int SEG_W = $bits(seg_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_C_FIND,
    S_C_POS,
    S_C_INS,
    S_C_REM,
    S_F_FIND,
    S_F_POS,
    S_F_DEC,
    S_F_REM,
    S_F_FREM,
    S_F_INS,
    S_RESP
  } state_t;

endpackage
`default_nettype wire

@@ src/first_fit_segment_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// First-fit segment allocator. The free and used segment tables each live in a
// single-port-read RAM with a registered read output, and a request walks
// them one entry per cycle: a claim scans the free table to the first fit,
// scans the used table for its sorted slot, shifts the used entries up and,
// on an exact fit, shifts the free entries down; a free scans the used table,
// scans the free table, shifts the used entries down and then merges, inserts
// or removes in the free table. One request is worked at a time, and the
// length of each walk is set by the one read port of each table. The result
// sits in an output register, so a new request may start while it waits.
// A write to the region start or size re-initializes both tables in the same
// cycle.
module first_fit_segment_allocator
  import ffsa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_func,
  input  wire logic [SIZE_W-1:0]    in_req_size,
  input  wire logic [ADDR_W-1:0]    in_free_addr,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [2:0]                out_status,
  output logic [ADDR_W-1:0]         out_value,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SIZE_W-1:0]    cfg_wdata
);

  state_t st_r, st_nxt;
  logic [START_W-1:0] start_r, start_nxt;
  logic [SIZE_W-1:0]  rsize_r, rsize_nxt;
  logic [CNT_W-1:0]   free_cnt_r, free_cnt_nxt, used_cnt_r, used_cnt_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt, pos_r, pos_nxt;
  logic               pend_r, pend_nxt;
  logic [IDX_W-1:0]   didx_r, didx_nxt, hit_r, hit_nxt;
  logic [SIZE_W-1:0]  req_r, req_nxt;
  logic [ADDR_W-1:0]  faddr_r, faddr_nxt;
  logic [ADDR_W-1:0]  seg_addr_r, seg_addr_nxt;
  logic [SIZE_W-1:0]  seg_size_r, seg_size_nxt;
  seg_t               prev_r, prev_nxt, cur_r, cur_nxt;
  logic               pred_r, pred_nxt, succ_r, succ_nxt;
  status_t            res_stat_r, res_stat_nxt;
  logic [ADDR_W-1:0]  res_val_r, res_val_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            out_stat_r, out_stat_nxt;
  logic [ADDR_W-1:0]  out_val_r, out_val_nxt;

  logic               fr_we, ur_we;
  logic [IDX_W-1:0]   fr_waddr, ur_waddr;
  seg_t               fr_wdata, ur_wdata;
  logic [SEG_W-1:0]   fr_rdata, ur_rdata;
  seg_t               fr_q, ur_q;

  logic [SIZE_W-1:0]  eff_size, eff_size_nxt;
  logic               f_more, u_more, f_down, u_down;
  logic               pred_c, succ_c;

  assign fr_q = seg_t'(fr_rdata);
  assign ur_q = seg_t'(ur_rdata);

  assign eff_size = (rsize_r > MAX_REGION) ? MAX_REGION : rsize_r;
  assign eff_size_nxt = (rsize_nxt > MAX_REGION) ? MAX_REGION : rsize_nxt;

  assign f_more = idx_r < free_cnt_r;
  assign u_more = idx_r < used_cnt_r;
  assign f_down = f_more && (idx_r >= pos_r);
  assign u_down = u_more && (idx_r >= pos_r);

  // The merge tests use one extra bit so that a segment ending at the top of
  // the address space never aliases a low address.
  assign pred_c = (pos_r != '0) &&
                  (({1'b0, prev_r.addr} + {1'b0, prev_r.size}) == {1'b0, faddr_r});
  assign succ_c = (pos_r < free_cnt_r) &&
                  (({1'b0, faddr_r} + {1'b0, seg_size_r}) == {1'b0, cur_r.addr});

  assign in_ready   = (st_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_stat_r;
  assign out_value  = out_val_r;

  ffsa_ram #(.WIDTH(SEG_W), .DEPTH(TABLE_ENTRIES)) u_free_ram (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (fr_rdata)
  );

  ffsa_ram #(.WIDTH(SEG_W), .DEPTH(TABLE_ENTRIES)) u_used_ram (
    .clk   (clk),
    .we    (ur_we),
    .waddr (ur_waddr),
    .wdata (ur_wdata),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (ur_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      start_r     <= '0;
      rsize_r     <= MAX_REGION;
      free_cnt_r  <= CNT_W'(1);
      used_cnt_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      start_r     <= start_nxt;
      rsize_r     <= rsize_nxt;
      free_cnt_r  <= free_cnt_nxt;
      used_cnt_r  <= used_cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    didx_r     <= didx_nxt;
    hit_r      <= hit_nxt;
    req_r      <= req_nxt;
    faddr_r    <= faddr_nxt;
    seg_addr_r <= seg_addr_nxt;
    seg_size_r <= seg_size_nxt;
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    pred_r     <= pred_nxt;
    succ_r     <= succ_nxt;
    res_stat_r <= res_stat_nxt;
    res_val_r  <= res_val_nxt;
    out_stat_r <= out_stat_nxt;
    out_val_r  <= out_val_nxt;
  end

  always_comb begin
    st_nxt        = st_r;
    start_nxt     = start_r;
    rsize_nxt     = rsize_r;
    free_cnt_nxt  = free_cnt_r;
    used_cnt_nxt  = used_cnt_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    pend_nxt      = 1'b0;
    didx_nxt      = idx_r[IDX_W-1:0];
    hit_nxt       = hit_r;
    req_nxt       = req_r;
    faddr_nxt     = faddr_r;
    seg_addr_nxt  = seg_addr_r;
    seg_size_nxt  = seg_size_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    pred_nxt      = pred_r;
    succ_nxt      = succ_r;
    res_stat_nxt  = res_stat_r;
    res_val_nxt   = res_val_r;
    out_valid_nxt = out_valid_r;
    out_stat_nxt  = out_stat_r;
    out_val_nxt   = out_val_r;
    fr_we    = 1'b0;
    fr_waddr = '0;
    fr_wdata = '0;
    ur_we    = 1'b0;
    ur_waddr = '0;
    ur_wdata = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_req_size;
          faddr_nxt = in_free_addr;
          idx_nxt   = '0;
          if (in_func == FUNC_FREE) begin
            st_nxt = S_F_FIND;
          end else if (in_req_size == '0 || in_req_size > eff_size) begin
            res_stat_nxt = STAT_BAD_SIZE;
            res_val_nxt  = '0;
            st_nxt       = S_RESP;
          end else begin
            st_nxt = S_C_FIND;
          end
        end
      end

      S_C_FIND: begin
        pend_nxt = f_more;
        if (f_more) idx_nxt = idx_r + 1'b1;
        if (pend_r && fr_q.size >= req_r) begin
          hit_nxt      = didx_r;
          seg_addr_nxt = fr_q.addr;
          seg_size_nxt = fr_q.size;
          pend_nxt     = 1'b0;
          if (used_cnt_r >= CNT_W'(TABLE_ENTRIES)) begin
            res_stat_nxt = STAT_FULL;
            res_val_nxt  = '0;
            st_nxt       = S_RESP;
          end else begin
            idx_nxt = '0;
            st_nxt  = S_C_POS;
          end
        end else if (!pend_r && !f_more) begin
          res_stat_nxt = STAT_NO_FIT;
          res_val_nxt  = '0;
          st_nxt       = S_RESP;
        end
      end

      S_C_POS: begin
        pend_nxt = u_more;
        if (u_more) idx_nxt = idx_r + 1'b1;
        if (pend_r && ur_q.addr >= seg_addr_r) begin
          pos_nxt  = CNT_W'(didx_r);
          idx_nxt  = used_cnt_r - 1'b1;
          pend_nxt = 1'b0;
          st_nxt   = S_C_INS;
        end else if (!pend_r && !u_more) begin
          pos_nxt  = used_cnt_r;
          idx_nxt  = used_cnt_r - 1'b1;
          st_nxt   = S_C_INS;
        end
      end

      // Shift used entries up by one, from the top down to the insert slot.
      S_C_INS: begin
        pend_nxt = u_down;
        if (u_down) idx_nxt = idx_r - 1'b1;
        if (pend_r) begin
          ur_we    = 1'b1;
          ur_waddr = didx_r + 1'b1;
          ur_wdata = ur_q;
        end else if (!u_down) begin
          ur_we         = 1'b1;
          ur_waddr      = pos_r[IDX_W-1:0];
          ur_wdata.addr = seg_addr_r;
          ur_wdata.size = req_r;
          used_cnt_nxt  = used_cnt_r + 1'b1;
          res_stat_nxt  = STAT_OK;
          res_val_nxt   = seg_addr_r;
          if (seg_size_r == req_r) begin
            idx_nxt = CNT_W'(hit_r) + 1'b1;
            st_nxt  = S_C_REM;
          end else begin
            fr_we         = 1'b1;
            fr_waddr      = hit_r;
            fr_wdata.addr = seg_addr_r + req_r;
            fr_wdata.size = seg_size_r - req_r;
            st_nxt        = S_RESP;
          end
        end
      end

      S_C_REM, S_F_FREM: begin
        pend_nxt = f_more;
        if (f_more) idx_nxt = idx_r + 1'b1;
        if (pend_r) begin
          fr_we    = 1'b1;
          fr_waddr = didx_r - 1'b1;
          fr_wdata = fr_q;
        end else if (!f_more) begin
          free_cnt_nxt = free_cnt_r - 1'b1;
          st_nxt       = S_RESP;
        end
      end

      S_F_FIND: begin
        pend_nxt = u_more;
        if (u_more) idx_nxt = idx_r + 1'b1;
        if (pend_r && ur_q.addr == faddr_r) begin
          hit_nxt      = didx_r;
          seg_size_nxt = ur_q.size;
          idx_nxt      = '0;
          pend_nxt     = 1'b0;
          st_nxt       = S_F_POS;
        end else if (!pend_r && !u_more) begin
          res_stat_nxt = STAT_NOT_ALLOC;
          res_val_nxt  = '0;
          st_nxt       = S_RESP;
        end
      end

      // The entry before the sorted slot is kept as the merge predecessor.
      S_F_POS: begin
        pend_nxt = f_more;
        if (f_more) idx_nxt = idx_r + 1'b1;
        if (pend_r) begin
          if (fr_q.addr >= faddr_r) begin
            pos_nxt  = CNT_W'(didx_r);
            cur_nxt  = fr_q;
            pend_nxt = 1'b0;
            st_nxt   = S_F_DEC;
          end else begin
            prev_nxt = fr_q;
          end
        end else if (!f_more) begin
          pos_nxt = free_cnt_r;
          st_nxt  = S_F_DEC;
        end
      end

      S_F_DEC: begin
        pred_nxt = pred_c;
        succ_nxt = succ_c;
        if (!pred_c && !succ_c && free_cnt_r >= CNT_W'(TABLE_ENTRIES)) begin
          res_stat_nxt = STAT_FULL;
          res_val_nxt  = '0;
          st_nxt       = S_RESP;
        end else begin
          idx_nxt = CNT_W'(hit_r) + 1'b1;
          st_nxt  = S_F_REM;
        end
      end

      S_F_REM: begin
        pend_nxt = u_more;
        if (u_more) idx_nxt = idx_r + 1'b1;
        if (pend_r) begin
          ur_we    = 1'b1;
          ur_waddr = didx_r - 1'b1;
          ur_wdata = ur_q;
        end else if (!u_more) begin
          used_cnt_nxt = used_cnt_r - 1'b1;
          res_stat_nxt = STAT_OK;
          res_val_nxt  = seg_size_r;
          if (pred_r) begin
            fr_we         = 1'b1;
            fr_waddr      = IDX_W'(pos_r - 1'b1);
            fr_wdata.addr = prev_r.addr;
            fr_wdata.size = succ_r ? (prev_r.size + seg_size_r + cur_r.size)
                                   : (prev_r.size + seg_size_r);
            if (succ_r) begin
              idx_nxt = pos_r + 1'b1;
              st_nxt  = S_F_FREM;
            end else begin
              st_nxt = S_RESP;
            end
          end else if (succ_r) begin
            fr_we         = 1'b1;
            fr_waddr      = pos_r[IDX_W-1:0];
            fr_wdata.addr = faddr_r;
            fr_wdata.size = cur_r.size + seg_size_r;
            st_nxt        = S_RESP;
          end else begin
            idx_nxt = free_cnt_r - 1'b1;
            st_nxt  = S_F_INS;
          end
        end
      end

      S_F_INS: begin
        pend_nxt = f_down;
        if (f_down) idx_nxt = idx_r - 1'b1;
        if (pend_r) begin
          fr_we    = 1'b1;
          fr_waddr = didx_r + 1'b1;
          fr_wdata = fr_q;
        end else if (!f_down) begin
          fr_we         = 1'b1;
          fr_waddr      = pos_r[IDX_W-1:0];
          fr_wdata.addr = faddr_r;
          fr_wdata.size = seg_size_r;
          free_cnt_nxt  = free_cnt_r + 1'b1;
          st_nxt        = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = res_stat_r;
          out_val_nxt   = res_val_r;
          st_nxt        = S_IDLE;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase

    // A region start or size write reloads the tables: one free segment over the region.
    if (cfg_we && (cfg_index == CFG_REGION_START || cfg_index == CFG_REGION_SIZE)) begin
      if (cfg_index == CFG_REGION_START) begin
        start_nxt = cfg_wdata[START_W-1:0];
      end else begin
        rsize_nxt = cfg_wdata;
      end
      free_cnt_nxt  = (eff_size_nxt != '0) ? CNT_W'(1) : '0;
      used_cnt_nxt  = '0;
      fr_we         = 1'b1;
      fr_waddr      = '0;
      fr_wdata.addr = {1'b0, start_nxt};
      fr_wdata.size = eff_size_nxt;
    end

    if (!rst_n) begin
      fr_we         = 1'b1;
      fr_waddr      = '0;
      fr_wdata.addr = '0;
      fr_wdata.size = MAX_REGION;
    end
  end

endmodule
`default_nettype wire

@@ src/ffsa_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ffsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/ffsa_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ffsa_checker
  import ffsa_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 in_func,
  input wire logic [SIZE_W-1:0]    in_req_size,
  input wire logic [ADDR_W-1:0]    in_free_addr,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [2:0]           out_status,
  input wire logic [ADDR_W-1:0]    out_value,
  input wire logic                 cfg_we,
  input wire logic [CFG_IDX_W-1:0] cfg_index,
  input wire logic [SIZE_W-1:0]    cfg_wdata
);

  // A result beat that is not taken holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_value))
    else $error("result beat changed while stalled");

  // A failed request never reports an address or a size.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_OK |-> out_value == '0)
    else $error("nonzero value on a failed request");

  // Every request leaves the idle state, so ready drops after an accept.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request accepted in back-to-back cycles");

  // A zero-size claim is rejected before any table is touched.
  a_zero_claim: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func == FUNC_CLAIM && in_req_size == '0 && !out_valid
    |=> ##1 out_valid && out_status == STAT_BAD_SIZE)
    else $error("zero-size claim not rejected");

endmodule

bind first_fit_segment_allocator ffsa_checker u_ffsa_checker (.*);
`default_nettype wire
